// ----- src/rrcd_pkg.sv -----
// shared constants, field widths and operation codes of the rank range deleter
package rrcd_pkg;

  // default sizes
  localparam int MAX_LENGTH_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 128;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int POS_W  = 11;
  localparam int CHAR_W = 7;
  localparam int CNT_W  = 11;

  // reset value of the length register
  localparam int LEN_RESET = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

endpackage

// ----- src/rrcd_ram.sv -----
// generic simple dual port ram with registered read
module rrcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rank_range_char_deleter.sv -----
// top level: string store with alive marks, fenwick counts and the item sequencer
//
// One item is worked at a time. After reset a clearing pass over all MAX_LENGTH
// positions marks every position alive and loads the tree; no item is taken meanwhile.
// A load writes its character, then hands on its result. A select takes one prefix
// query, then a binary search of about log2(N) steps, each one a prefix query, then
// the character read. A delete runs two such searches, then a scan that reads each
// position in the span, plus a read-modify-write of each tree entry touched for each
// killed position (up to log2(N)+1 entries) and a check that closes that update. The
// pace is set by the single read port of the count memory, which serves every prefix
// step, scan read and read-modify-write. A finished result sits in an output
// register, so the next item may enter while it waits.
module rank_range_char_deleter
  import rrcd_pkg::*;
#(
  parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [POS_W-1:0]  cfg_string_length,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [POS_W-1:0]  in_position,
  input  logic [CHAR_W-1:0] in_char_value,
  input  logic [POS_W-1:0]  in_rank_low,
  input  logic [POS_W-1:0]  in_rank_high,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_out,
  output logic [CNT_W-1:0]  out_deleted_count,
  output logic              out_found
);

  localparam int PW = $clog2(MAX_LENGTH + 1);
  localparam int AW = $clog2(MAX_LENGTH);
  localparam int QW = PW + 1;
  localparam int CW = $clog2(ALPHABET_SIZE);
  localparam int VW = (PW > POS_W) ? PW : POS_W;
  localparam int SW = PW + 1;
  localparam logic [PW-1:0] MAXP    = PW'(MAX_LENGTH);
  localparam logic [PW-1:0] LEN_RST = (LEN_RESET > MAX_LENGTH) ? MAXP : PW'(LEN_RESET);

  typedef enum logic [11:0] {
    S_CLR   = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_SRCH  = 12'b0000_0000_0100,
    S_PFX   = 12'b0000_0000_1000,
    S_CMP   = 12'b0000_0001_0000,
    S_SC_RD = 12'b0000_0010_0000,
    S_SC_CK = 12'b0000_0100_0000,
    S_UP_RD = 12'b0000_1000_0000,
    S_UP_WR = 12'b0001_0000_0000,
    S_SEL_RD = 12'b0010_0000_0000,
    S_SEL_WT = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  function automatic logic [QW-1:0] lowbit(input logic [QW-1:0] v);
    return v & (~v + QW'(1));
  endfunction

  state_t            state_r, state_nxt;
  logic [PW-1:0]     len_r, len_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [POS_W-1:0]  rank_r, rank_nxt;
  logic [POS_W-1:0]  rhi_r, rhi_nxt;
  logic [CW-1:0]     ch_r, ch_nxt;
  logic [PW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [PW-1:0]     pq_r, pq_nxt, sum_r, sum_nxt;
  logic              pend_r, pend_nxt;
  logic              kind_r, kind_nxt, second_r, second_nxt, tot_r, tot_nxt;
  logic [PW-1:0]     p_r, p_nxt, b_r, b_nxt, clr_r, clr_nxt, killed_r, killed_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic              found_r, found_nxt;
  logic [CHAR_W-1:0] cout_r, cout_nxt;
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] oc_r, oc_nxt;
  logic [CNT_W-1:0]  od_r, od_nxt;
  logic              of_r, of_nxt;

  // memory ports
  logic          st_we, ch_we;
  logic [AW-1:0] st_waddr, st_raddr, ch_waddr, ch_raddr;
  logic [SW-1:0] st_wdata, st_rdata;
  logic [CW-1:0] ch_wdata, ch_rdata;

  logic [15:0]   ch_mod;
  logic [PW-1:0] cfg_len;
  logic [QW-1:0] mid_sum;
  logic          alive_rd;
  logic [PW-1:0] fen_rd;

  // alive mark and count per position
  rrcd_ram #(.WIDTH(SW), .DEPTH(MAX_LENGTH)) u_state_ram (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // stored characters
  rrcd_ram #(.WIDTH(CW), .DEPTH(MAX_LENGTH)) u_char_ram (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  assign alive_rd = st_rdata[PW];
  assign fen_rd   = st_rdata[PW-1:0];

  // character folded into the alphabet by restoring subtraction
  always_comb begin
    ch_mod = 16'(in_char_value);
    for (int b = 6; b >= 0; b--) begin
      if (ch_mod >= 16'(ALPHABET_SIZE << b)) begin
        ch_mod = ch_mod - 16'(ALPHABET_SIZE << b);
      end
    end
  end

  // clamped length write
  always_comb begin
    if (cfg_string_length == '0) begin
      cfg_len = PW'(1);
    end else if (VW'(cfg_string_length) > VW'(MAXP)) begin
      cfg_len = MAXP;
    end else begin
      cfg_len = PW'(cfg_string_length);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign mid_sum   = QW'(lo_r) + QW'(hi_r) + QW'(kind_r);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    op_nxt     = op_r;
    rank_nxt   = rank_r;
    rhi_nxt    = rhi_r;
    ch_nxt     = ch_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    pq_nxt     = pq_r;
    sum_nxt    = sum_r;
    pend_nxt   = pend_r;
    kind_nxt   = kind_r;
    second_nxt = second_r;
    tot_nxt    = tot_r;
    p_nxt      = p_r;
    b_nxt      = b_r;
    clr_nxt    = clr_r;
    killed_nxt = killed_r;
    q_nxt      = q_r;
    found_nxt  = found_r;
    cout_nxt   = cout_r;
    ov_nxt     = ov_r;
    oc_nxt     = oc_r;
    od_nxt     = od_r;
    of_nxt     = of_r;
    st_we      = 1'b0;
    st_waddr   = AW'(p_r - PW'(1));
    st_wdata   = '0;
    st_raddr   = AW'(p_r - PW'(1));
    ch_we      = 1'b0;
    ch_waddr   = AW'(in_position - POS_W'(1));
    ch_wdata   = CW'(ch_mod);
    ch_raddr   = AW'(p_r - PW'(1));

    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      len_nxt = cfg_len;
    end

    case (state_r)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = AW'(clr_r - PW'(1));
        st_wdata = {1'b1, PW'(lowbit(QW'(clr_r)))};
        clr_nxt  = clr_r + PW'(1);
        if (clr_r == MAXP) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          ch_nxt     = CW'(ch_mod);
          rhi_nxt    = in_rank_high;
          found_nxt  = 1'b1;
          killed_nxt = '0;
          cout_nxt   = '0;
          lo_nxt     = PW'(1);
          hi_nxt     = len_r;
          kind_nxt   = 1'b0;
          second_nxt = 1'b0;
          tot_nxt    = 1'b0;
          state_nxt  = S_DONE;
          case (in_operation)
            OP_LOAD: begin
              ch_we = (in_position != '0) && (VW'(in_position) <= VW'(len_r));
            end
            OP_DELETE: begin
              rank_nxt  = in_rank_low;
              state_nxt = S_SRCH;
            end
            OP_SELECT: begin
              rank_nxt = in_position;
              if (in_position == '0) begin
                found_nxt = 1'b0;
              end else begin
                tot_nxt   = 1'b1;
                pq_nxt    = len_r;
                sum_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_PFX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = PW'(mid_sum >> 1);
          pq_nxt    = PW'(mid_sum >> 1);
          sum_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_PFX;
        end else if (op_r == OP_DELETE) begin
          if (!second_r) begin
            p_nxt      = hi_r;
            second_nxt = 1'b1;
            kind_nxt   = 1'b1;
            rank_nxt   = rhi_r;
            lo_nxt     = PW'(1);
            hi_nxt     = len_r;
          end else begin
            b_nxt     = lo_r;
            state_nxt = (p_r > lo_r) ? S_DONE : S_SC_RD;
          end
        end else begin
          p_nxt     = hi_r;
          state_nxt = S_SEL_RD;
        end
      end
      // prefix sum: one tree read per cycle, data summed in the cycle after its read
      S_PFX: begin
        st_raddr = AW'(pq_r - PW'(1));
        if (pend_r) begin
          sum_nxt = sum_r + fen_rd;
        end
        if (pq_r != '0) begin
          pq_nxt   = pq_r - PW'(lowbit(QW'(pq_r)));
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        state_nxt = S_SRCH;
        if (tot_r) begin
          tot_nxt = 1'b0;
          if (VW'(sum_r) < VW'(rank_r)) begin
            found_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end else if (!kind_r) begin
          if (VW'(sum_r) >= VW'(rank_r)) hi_nxt = mid_r;
          else lo_nxt = mid_r + PW'(1);
        end else begin
          if (VW'(sum_r) <= VW'(rank_r)) lo_nxt = mid_r;
          else hi_nxt = mid_r - PW'(1);
        end
      end
      S_SC_RD: begin
        state_nxt = S_SC_CK;
      end
      // kill on match, else step to the next position or finish at the span's end
      S_SC_CK: begin
        if (alive_rd && ch_rdata == ch_r) begin
          st_we      = 1'b1;
          st_wdata   = {1'b0, fen_rd - PW'(1)};
          killed_nxt = killed_r + PW'(1);
          q_nxt      = QW'(p_r) + lowbit(QW'(p_r));
          state_nxt  = S_UP_RD;
        end else if (p_r == b_r) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt     = p_r + PW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_UP_RD: begin
        st_raddr = AW'(q_r - QW'(1));
        if (q_r <= QW'(len_r)) begin
          state_nxt = S_UP_WR;
        end else if (p_r == b_r) begin
          state_nxt = S_DONE;
        end else begin
          p_nxt     = p_r + PW'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_UP_WR: begin
        st_we     = 1'b1;
        st_waddr  = AW'(q_r - QW'(1));
        st_wdata  = {alive_rd, fen_rd - PW'(1)};
        q_nxt     = q_r + lowbit(q_r);
        state_nxt = S_UP_RD;
      end
      S_SEL_RD: begin
        state_nxt = S_SEL_WT;
      end
      S_SEL_WT: begin
        cout_nxt  = CHAR_W'(ch_rdata);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oc_nxt    = cout_r;
          od_nxt    = CNT_W'(killed_r);
          of_nxt    = found_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      len_r   <= LEN_RST;
      clr_r   <= PW'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    rank_r   <= rank_nxt;
    rhi_r    <= rhi_nxt;
    ch_r     <= ch_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    pq_r     <= pq_nxt;
    sum_r    <= sum_nxt;
    pend_r   <= pend_nxt;
    kind_r   <= kind_nxt;
    second_r <= second_nxt;
    tot_r    <= tot_nxt;
    p_r      <= p_nxt;
    b_r      <= b_nxt;
    killed_r <= killed_nxt;
    q_r      <= q_nxt;
    found_r  <= found_nxt;
    cout_r   <= cout_nxt;
    oc_r     <= oc_nxt;
    od_r     <= od_nxt;
    of_r     <= of_nxt;
  end

  assign out_valid         = ov_r;
  assign out_char_out      = oc_r;
  assign out_deleted_count = od_r;
  assign out_found         = of_r;

  // no item enters during the clearing pass
  ap_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready) else $error("item taken during clearing pass");

  // scan pointer stays inside the string
  ap_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SC_RD |-> (p_r != '0 && p_r <= len_r)) else $error("scan out of range");

  // a missed select carries no character and no kill count
  ap_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_char_out == '0 && out_deleted_count == '0))
    else $error("not-found result with payload");

  // length register stays in its legal range
  ap_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0 && len_r <= MAXP)) else $error("length out of range");

endmodule

// ----- tb/tb_rank_range_char_deleter.sv -----
// self-checking testbench for the rank range character deleter
module tb_rank_range_char_deleter;
  import rrcd_pkg::*;

  localparam int NMAX = MAX_LENGTH_DEF;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [POS_W-1:0]  cfg_string_length;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [POS_W-1:0]  in_position;
  logic [CHAR_W-1:0] in_char_value;
  logic [POS_W-1:0]  in_rank_low;
  logic [POS_W-1:0]  in_rank_high;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] out_char_out;
  logic [CNT_W-1:0]  out_deleted_count;
  logic              out_found;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  rlo;
    logic [POS_W-1:0]  rhi;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  killed;
    logic              found;
  } result_t;

  // directed row: item, and a typed-in answer where it is obvious
  typedef struct packed {
    item_t   it;
    logic    has_ans;
    result_t ans;
  } row_t;

  rank_range_char_deleter dut (.*);

  // shadow state of the string
  int unsigned       cur_len;
  logic [CHAR_W-1:0] chars [1:NMAX];
  bit                loaded [1:NMAX];
  bit                alive [1:NMAX];
  int                tree [1:NMAX];

  result_t expected_q [$];
  int      errors;
  int      cycles;
  bit      hold_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rank_range_char_deleter failed");
      $finish;
    end
  end

  function automatic int unsigned lowbit(int unsigned v);
    return v & (~v + 1);
  endfunction

  function automatic int alive_prefix(int unsigned p);
    int s;
    s = 0;
    if (p > NMAX) p = NMAX;
    while (p >= 1) begin
      s += tree[p];
      p -= lowbit(p);
    end
    return s;
  endfunction

  function automatic int unsigned pos_of_rank_lo(int rk);
    int unsigned lo, hi, mid;
    lo = 1;
    hi = cur_len;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (alive_prefix(mid) >= rk) hi = mid;
      else lo = mid + 1;
    end
    return hi;
  endfunction

  function automatic int unsigned pos_of_rank_hi(int rk);
    int unsigned lo, hi, mid;
    lo = 1;
    hi = cur_len;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (alive_prefix(mid) <= rk) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // apply one item to the shadow state and return its result
  function automatic result_t apply_item(item_t it);
    result_t r;
    int unsigned a, b, p, q;
    r = '0;
    r.found = 1'b1;
    case (it.op)
      OP_LOAD: begin
        if (it.pos >= 1 && it.pos <= cur_len) begin
          chars[it.pos] = it.ch;
          loaded[it.pos] = 1'b1;
        end
      end
      OP_DELETE: begin
        a = pos_of_rank_lo(int'(it.rlo));
        b = pos_of_rank_hi(int'(it.rhi));
        for (p = a; p <= b && p <= cur_len; p++) begin
          if (alive[p] && chars[p] == it.ch) begin
            alive[p] = 1'b0;
            q = p;
            while (q >= 1 && q <= cur_len) begin
              tree[q]--;
              q += lowbit(q);
            end
            r.killed++;
          end
        end
      end
      OP_SELECT: begin
        if (it.pos >= 1 && alive_prefix(cur_len) >= int'(it.pos))
          r.ch = chars[pos_of_rank_lo(int'(it.pos))];
        else
          r.found = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker with its own stall pattern
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("beat with no expectation", int'(out_found), 0);
      end else begin
        want = expected_q.pop_front();
        if (out_char_out !== want.ch)
          report_mismatch("char_out", int'(out_char_out), int'(want.ch));
        if (out_deleted_count !== want.killed)
          report_mismatch("deleted_count", int'(out_deleted_count), int'(want.killed));
        if (out_found !== want.found)
          report_mismatch("found", int'(out_found), int'(want.found));
      end
    end
    if (hold_out || cycles % 256 < 64) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0) && (cycles % 37 > 4);
  end

  // true when a delete would compare a never-loaded position
  function automatic bit touches_unloaded(item_t it);
    int unsigned a, b, p;
    if (it.op != OP_DELETE) return 1'b0;
    a = pos_of_rank_lo(int'(it.rlo));
    b = pos_of_rank_hi(int'(it.rhi));
    for (p = a; p <= b && p <= cur_len; p++)
      if (alive[p] && !loaded[p]) return 1'b1;
    return 1'b0;
  endfunction

  // drive one item and queue its prediction
  task automatic send_item(item_t it, bit has_ans, result_t ans);
    result_t r;
    r = apply_item(it);
    if (has_ans && r !== ans) report_mismatch("directed row", int'(r), int'(ans));
    expected_q.push_back(r);
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_position <= it.pos;
    in_char_value <= it.ch;
    in_rank_low <= it.rlo;
    in_rank_high <= it.rhi;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_length(int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    cfg_string_length <= v[POS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_len = (v & 11'h7ff) < 1 ? 1 : ((v & 11'h7ff) > NMAX ? NMAX : (v & 11'h7ff));
  endtask

  // fill positions 1..n with chars from a small alphabet
  task automatic load_all(int unsigned n, int unsigned alpha);
    item_t it;
    for (int unsigned p = 1; p <= n; p++) begin
      it = '{OP_LOAD, p[POS_W-1:0], CHAR_W'($urandom_range(0, alpha - 1)), '0, '0};
      send_item(it, 1'b0, '0);
      if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 5));
    end
  endtask

  function automatic item_t random_item(int unsigned alpha);
    item_t it;
    int unsigned sel;
    it.pos = POS_W'($urandom_range(0, cur_len + 2));
    it.ch = CHAR_W'($urandom_range(0, alpha - 1));
    it.rlo = POS_W'($urandom_range(0, cur_len + 1));
    it.rhi = POS_W'($urandom_range(0, cur_len + 1));
    sel = $urandom_range(0, 99);
    if (sel < 45) it.op = OP_DELETE;
    else if (sel < 80) it.op = OP_SELECT;
    else if (sel < 95) it.op = OP_LOAD;
    else it.op = OP_NONE;
    if (sel % 10 == 0) begin
      it.pos = POS_W'($urandom);
      it.ch = CHAR_W'($urandom);
      it.rlo = POS_W'($urandom);
      it.rhi = POS_W'($urandom);
    end
    return it;
  endfunction

  // random phase: bursts with gaps, unsafe deletes turned into selects
  task automatic random_phase(int n, int unsigned alpha);
    item_t it;
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      it = random_item(alpha);
      if (touches_unloaded(it)) it.op = OP_SELECT;
      send_item(it, 1'b0, '0);
      if (burst == 0) begin
        idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
        burst = $urandom_range(1, 15);
      end else begin
        burst--;
      end
    end
  endtask

  row_t rows [$];

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_string_length = '0;
    in_valid = 1'b0;
    in_operation = '0;
    in_position = '0;
    in_char_value = '0;
    in_rank_low = '0;
    in_rank_high = '0;
    out_ready = 1'b0;
    hold_out = 1'b0;
    errors = 0;
    cycles = 0;
    cur_len = LEN_RESET;
    for (int i = 1; i <= NMAX; i++) begin
      chars[i] = '0;
      loaded[i] = 1'b0;
      alive[i] = 1'b1;
      tree[i] = lowbit(i);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset length: selects before any load, then loads and selects at the ends
    rows.push_back('{'{OP_SELECT, 11'd0, 7'd0, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b0}});
    rows.push_back('{'{OP_SELECT, 11'd1025, 7'd0, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b0}});
    rows.push_back('{'{OP_SELECT, 11'h7ff, 7'd0, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b0}});
    rows.push_back('{'{OP_LOAD, 11'd0, 7'h7f, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b1}});
    rows.push_back('{'{OP_LOAD, 11'd1025, 7'h7f, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b1}});
    rows.push_back('{'{OP_LOAD, 11'h7ff, 7'h55, 11'h7ff, 11'h7ff},
                     1'b1, '{7'd0, 11'd0, 1'b1}});
    rows.push_back('{'{OP_NONE, 11'h7ff, 7'h7f, 11'h7ff, 11'h7ff},
                     1'b1, '{7'd0, 11'd0, 1'b1}});
    rows.push_back('{'{OP_LOAD, 11'd1, 7'h7f, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b1}});
    rows.push_back('{'{OP_LOAD, 11'd1024, 7'h2a, 11'd0, 11'd0}, 1'b1, '{7'd0, 11'd0, 1'b1}});
    rows.push_back('{'{OP_SELECT, 11'd1, 7'd0, 11'd0, 11'd0}, 1'b1, '{7'h7f, 11'd0, 1'b1}});
    rows.push_back('{'{OP_SELECT, 11'd1024, 7'd0, 11'd0, 11'd0}, 1'b1, '{7'h2a, 11'd0, 1'b1}});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_ans, rows[i].ans);

    // small string: fill, then directed deletes incl. empty and inverted spans
    set_length(0);
    set_length(2047);
    set_length(16);
    load_all(16, 3);
    rows.delete();
    rows.push_back('{'{OP_DELETE, 11'd5, 7'd0, 11'd3, 11'd2}, 1'b0, '0});
    rows.push_back('{'{OP_DELETE, 11'd0, 7'd1, 11'd1, 11'd16}, 1'b0, '0});
    rows.push_back('{'{OP_LOAD, 11'd3, 7'd2, 11'd0, 11'd0}, 1'b0, '0});
    rows.push_back('{'{OP_DELETE, 11'd0, 7'd0, 11'd0, 11'h7ff}, 1'b0, '0});
    rows.push_back('{'{OP_SELECT, 11'd2, 7'd0, 11'd0, 11'd0}, 1'b0, '0});
    rows.push_back('{'{OP_DELETE, 11'd0, 7'd2, 11'h7ff, 11'd0}, 1'b0, '0});
    rows.push_back('{'{OP_SELECT, 11'd1, 7'd0, 11'd0, 11'd0}, 1'b0, '0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_ans, rows[i].ans);

    // sender waits until every result is in
    drain();
    hold_out = 1'b1;
    random_phase(40, 3);
    hold_out = 1'b0;

    // length 1, then grow after deletes
    set_length(1);
    load_all(1, 2);
    random_phase(20, 2);
    set_length(64);
    load_all(64, 4);
    random_phase(120, 4);
    set_length(100);
    load_all(100, 8);
    random_phase(30, 8);

    drain();
    if (errors == 0) begin
      $display("tb_rank_range_char_deleter passed");
    end else begin
      $display("tb_rank_range_char_deleter failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rrcd_pkg.sv
src/rrcd_ram.sv
src/rank_range_char_deleter.sv
tb/tb_rank_range_char_deleter.sv
